/* rtl/coit_pkg.sv */
// shared types, codes and defaults for the chunk offset index table
package coit_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_OFFSET_BITS = 48;
    localparam int HASH_W          = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_COMPARE,
        S_FETCH_RD,
        S_FETCH,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic step;
        logic addr_fetch;
        logic load_data;
        logic load_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_search;
        logic go_fetch;
        logic search_done;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/chunk_offset_index_table.sv */
// top level of the chunk offset index table
//
//   channel | direction | handshake          | word
//   s_      | in        | s_valid / s_ready  | command, chunk lengths, hash, range, index
//   m_      | out       | m_valid / m_ready  | status, offsets, lengths, hash, count, total
//
// states from acceptance to the result word being loaded:
//   clear, append and any error: execute, finish; get: execute, fetch read, fetch;
//   range query: execute, then the binary search loop on the original-end memory
//   until both bounds meet (one registered read and one compare per step, both
//   bound searches on its two read ports), then fetch read and fetch
// s_ready is high only while the sequencer is idle; one word is in work at a time
// the result register holds a finished word while the next one is taken in;
// a new result waits in its last state until m_ready frees that register
// reset (aresetn low, synchronous) empties the table; no clearing pass is run
module chunk_offset_index_table import coit_pkg::*; #(
    parameter  int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter  int OFFSET_BITS = DEF_OFFSET_BITS,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // command words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [OFFSET_BITS-1:0] s_chunk_orig_len,
    input  logic [OFFSET_BITS-1:0] s_chunk_comp_len,
    input  logic [HASH_W-1:0]      s_chunk_hash,
    input  logic [OFFSET_BITS-1:0] s_range_start,
    input  logic [OFFSET_BITS-1:0] s_range_length,
    input  logic [IDX_W-1:0]       s_entry_index,
    // result words
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [OFFSET_BITS-1:0] m_comp_offset,
    output logic [OFFSET_BITS-1:0] m_comp_length,
    output logic [OFFSET_BITS-1:0] m_orig_offset,
    output logic [OFFSET_BITS-1:0] m_orig_length,
    output logic [OFFSET_BITS-1:0] m_inner_offset,
    output logic [HASH_W-1:0]      m_entry_hash,
    output logic [CNT_W-1:0]       m_entry_count,
    output logic [OFFSET_BITS-1:0] m_total_orig_len
);

    // command and status between sequencer and datapath
    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // sequencer: idle, execute, search loop, fetch, result hand-off
    coit_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    // datapath: table memories, running ends, search bounds, result register
    coit_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl_cmd         (ctrl_cmd),
        .dp_status        (dp_status),
        .s_cmd            (s_cmd),
        .s_chunk_orig_len (s_chunk_orig_len),
        .s_chunk_comp_len (s_chunk_comp_len),
        .s_chunk_hash     (s_chunk_hash),
        .s_range_start    (s_range_start),
        .s_range_length   (s_range_length),
        .s_entry_index    (s_entry_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_comp_offset    (m_comp_offset),
        .m_comp_length    (m_comp_length),
        .m_orig_offset    (m_orig_offset),
        .m_orig_length    (m_orig_length),
        .m_inner_offset   (m_inner_offset),
        .m_entry_hash     (m_entry_hash),
        .m_entry_count    (m_entry_count),
        .m_total_orig_len (m_total_orig_len)
    );

endmodule

/* rtl/coit_ctrl.sv */
// command sequencer for the chunk offset index table
module coit_ctrl import coit_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  ctrl_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (dp_status.go_search) begin
                    state_next = S_SEARCH;
                end else if (dp_status.go_fetch) begin
                    state_next = S_FETCH_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SEARCH: begin
                state_next = dp_status.search_done ? S_FETCH_RD : S_COMPARE;
            end
            S_COMPARE: begin
                state_next = S_SEARCH;
            end
            S_FETCH_RD: begin
                state_next = S_FETCH;
            end
            S_FETCH: begin
                if (dp_status.out_free) state_next = S_IDLE;
            end
            S_FINISH: begin
                if (dp_status.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl_cmd = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready          = 1'b1;
                ctrl_cmd.load_in = s_valid;
            end
            S_EXEC:     ctrl_cmd.exec = 1'b1;
            S_SEARCH:   ;
            S_COMPARE:  ctrl_cmd.step = 1'b1;
            S_FETCH_RD: ctrl_cmd.addr_fetch = 1'b1;
            S_FETCH: begin
                ctrl_cmd.addr_fetch = 1'b1;
                ctrl_cmd.load_data  = dp_status.out_free;
            end
            S_FINISH:   ctrl_cmd.load_status = dp_status.out_free;
            default:    ;
        endcase
    end

endmodule

/* rtl/coit_dp.sv */
// table memories, search registers, arithmetic and result register
module coit_dp import coit_pkg::*; #(
    parameter  int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter  int OFFSET_BITS = DEF_OFFSET_BITS,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_cmd_t              ctrl_cmd,
    output dp_status_t             dp_status,
    input  logic [1:0]             s_cmd,
    input  logic [OFFSET_BITS-1:0] s_chunk_orig_len,
    input  logic [OFFSET_BITS-1:0] s_chunk_comp_len,
    input  logic [HASH_W-1:0]      s_chunk_hash,
    input  logic [OFFSET_BITS-1:0] s_range_start,
    input  logic [OFFSET_BITS-1:0] s_range_length,
    input  logic [IDX_W-1:0]       s_entry_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [OFFSET_BITS-1:0] m_comp_offset,
    output logic [OFFSET_BITS-1:0] m_comp_length,
    output logic [OFFSET_BITS-1:0] m_orig_offset,
    output logic [OFFSET_BITS-1:0] m_orig_length,
    output logic [OFFSET_BITS-1:0] m_inner_offset,
    output logic [HASH_W-1:0]      m_entry_hash,
    output logic [CNT_W-1:0]       m_entry_count,
    output logic [OFFSET_BITS-1:0] m_total_orig_len
);

    // captured word
    cmd_t                   cmd_reg;
    logic [OFFSET_BITS-1:0] olen_reg;
    logic [OFFSET_BITS-1:0] clen_reg;
    logic [HASH_W-1:0]      hash_in_reg;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] len_reg;
    logic [IDX_W-1:0]       idx_reg;

    // table state
    logic [CNT_W-1:0]       count_reg;
    logic [OFFSET_BITS-1:0] total_comp_reg;
    logic [OFFSET_BITS-1:0] total_orig_reg;

    logic [OFFSET_BITS-1:0] comp_end_mem [TABLE_DEPTH];
    logic [OFFSET_BITS-1:0] orig_end_mem [TABLE_DEPTH];
    logic [HASH_W-1:0]      hash_mem     [TABLE_DEPTH];

    logic [OFFSET_BITS-1:0] comp_rd_a_reg;
    logic [OFFSET_BITS-1:0] comp_rd_b_reg;
    logic [OFFSET_BITS-1:0] orig_rd_a_reg;
    logic [OFFSET_BITS-1:0] orig_rd_b_reg;
    logic [HASH_W-1:0]      hash_rd_b_reg;

    // binary search bounds: a finds the first chunk, b the last
    logic [IDX_W-1:0]       lo_a_reg;
    logic [IDX_W-1:0]       hi_a_reg;
    logic [IDX_W-1:0]       lo_b_reg;
    logic [IDX_W-1:0]       hi_b_reg;
    status_t                status_reg;

    // result register
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [OFFSET_BITS-1:0] m_comp_offset_reg;
    logic [OFFSET_BITS-1:0] m_comp_length_reg;
    logic [OFFSET_BITS-1:0] m_orig_offset_reg;
    logic [OFFSET_BITS-1:0] m_orig_length_reg;
    logic [OFFSET_BITS-1:0] m_inner_offset_reg;
    logic [HASH_W-1:0]      m_entry_hash_reg;
    logic [CNT_W-1:0]       m_entry_count_reg;
    logic [OFFSET_BITS-1:0] m_total_orig_len_reg;

    logic [OFFSET_BITS:0]   comp_sum;
    logic [OFFSET_BITS:0]   orig_sum;
    logic [OFFSET_BITS:0]   stop_sum;
    logic [OFFSET_BITS-1:0] stop;
    status_t                exec_status;
    logic                   append_ok;
    logic [CNT_W-1:0]       cnt_m1;
    logic [IDX_W:0]         mid_a_sum;
    logic [IDX_W:0]         mid_b_sum;
    logic [IDX_W-1:0]       mid_a;
    logic [IDX_W-1:0]       mid_b;
    logic [IDX_W-1:0]       addr_a;
    logic [IDX_W-1:0]       addr_b;
    logic                   first_gt;
    logic                   last_ge;
    logic                   first_zero;
    logic [OFFSET_BITS-1:0] coff;
    logic [OFFSET_BITS-1:0] ooff;
    logic                   out_free;

    assign comp_sum = {1'b0, total_comp_reg} + {1'b0, clen_reg};
    assign orig_sum = {1'b0, total_orig_reg} + {1'b0, olen_reg};
    assign stop_sum = {1'b0, start_reg} + {1'b0, len_reg};
    assign stop     = stop_sum[OFFSET_BITS-1:0];
    assign cnt_m1   = count_reg - CNT_W'(1);

    always_comb begin
        exec_status = ST_OK;
        unique case (cmd_reg)
            CMD_CLEAR:  exec_status = ST_OK;
            CMD_APPEND: begin
                if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                    exec_status = ST_FULL;
                end else if (comp_sum[OFFSET_BITS] || orig_sum[OFFSET_BITS]) begin
                    exec_status = ST_OVERFLOW;
                end
            end
            CMD_QUERY: begin
                // an empty table has a zero total, so start >= total covers it
                if (len_reg == '0 || start_reg >= total_orig_reg
                    || stop_sum > {1'b0, total_orig_reg}) begin
                    exec_status = ST_RANGE;
                end
            end
            CMD_GET: begin
                if ({1'b0, idx_reg} >= count_reg) exec_status = ST_BAD_INDEX;
            end
            default: exec_status = ST_OK;
        endcase
    end

    assign append_ok = (cmd_reg == CMD_APPEND) && (exec_status == ST_OK);

    assign mid_a_sum = {1'b0, lo_a_reg} + {1'b0, hi_a_reg};
    assign mid_b_sum = {1'b0, lo_b_reg} + {1'b0, hi_b_reg};
    assign mid_a     = mid_a_sum[IDX_W:1];
    assign mid_b     = mid_b_sum[IDX_W:1];
    assign addr_a    = ctrl_cmd.addr_fetch ? lo_a_reg - IDX_W'(1) : mid_a;
    assign addr_b    = ctrl_cmd.addr_fetch ? lo_b_reg : mid_b;

    assign first_gt  = orig_rd_a_reg > start_reg;
    assign last_ge   = orig_rd_b_reg >= stop;

    assign first_zero = (lo_a_reg == '0);
    assign coff       = first_zero ? '0 : comp_rd_a_reg;
    assign ooff       = first_zero ? '0 : orig_rd_a_reg;

    assign out_free = !m_valid_reg || m_ready;

    assign dp_status.go_search   = (cmd_reg == CMD_QUERY) && (exec_status == ST_OK);
    assign dp_status.go_fetch    = (cmd_reg == CMD_GET) && (exec_status == ST_OK);
    assign dp_status.search_done = (lo_a_reg == hi_a_reg) && (lo_b_reg == hi_b_reg);
    assign dp_status.out_free    = out_free;

    // control and table bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            total_comp_reg <= '0;
            total_orig_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (ctrl_cmd.exec) begin
                if (cmd_reg == CMD_CLEAR) begin
                    count_reg      <= '0;
                    total_comp_reg <= '0;
                    total_orig_reg <= '0;
                end else if (append_ok) begin
                    count_reg      <= count_reg + CNT_W'(1);
                    total_comp_reg <= comp_sum[OFFSET_BITS-1:0];
                    total_orig_reg <= orig_sum[OFFSET_BITS-1:0];
                end
            end
            if (ctrl_cmd.load_data || ctrl_cmd.load_status) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // memories: one write port, registered reads on two addresses
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.exec && append_ok) begin
            comp_end_mem[count_reg[IDX_W-1:0]] <= comp_sum[OFFSET_BITS-1:0];
            orig_end_mem[count_reg[IDX_W-1:0]] <= orig_sum[OFFSET_BITS-1:0];
            hash_mem[count_reg[IDX_W-1:0]]     <= hash_in_reg;
        end
        comp_rd_a_reg <= comp_end_mem[addr_a];
        comp_rd_b_reg <= comp_end_mem[addr_b];
        orig_rd_a_reg <= orig_end_mem[addr_a];
        orig_rd_b_reg <= orig_end_mem[addr_b];
        hash_rd_b_reg <= hash_mem[addr_b];
    end

    // captured word, search bounds and result payload
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.load_in) begin
            cmd_reg     <= cmd_t'(s_cmd);
            olen_reg    <= s_chunk_orig_len;
            clen_reg    <= s_chunk_comp_len;
            hash_in_reg <= s_chunk_hash;
            start_reg   <= s_range_start;
            len_reg     <= s_range_length;
            idx_reg     <= s_entry_index;
        end

        if (ctrl_cmd.exec) begin
            status_reg <= exec_status;
            lo_a_reg   <= (cmd_reg == CMD_GET) ? idx_reg : '0;
            lo_b_reg   <= (cmd_reg == CMD_GET) ? idx_reg : '0;
            hi_a_reg   <= cnt_m1[IDX_W-1:0];
            hi_b_reg   <= cnt_m1[IDX_W-1:0];
        end else if (ctrl_cmd.step) begin
            if (lo_a_reg != hi_a_reg) begin
                if (first_gt) begin
                    hi_a_reg <= mid_a;
                end else begin
                    lo_a_reg <= mid_a + IDX_W'(1);
                end
            end
            if (lo_b_reg != hi_b_reg) begin
                if (last_ge) begin
                    hi_b_reg <= mid_b;
                end else begin
                    lo_b_reg <= mid_b + IDX_W'(1);
                end
            end
        end

        if (ctrl_cmd.load_data) begin
            m_status_reg      <= ST_OK;
            m_comp_offset_reg <= coff;
            m_comp_length_reg <= comp_rd_b_reg - coff;
            m_orig_offset_reg <= ooff;
            m_orig_length_reg <= orig_rd_b_reg - ooff;
            m_inner_offset_reg <= (cmd_reg == CMD_QUERY) ? start_reg - ooff : '0;
            m_entry_hash_reg  <= (cmd_reg == CMD_GET) ? hash_rd_b_reg : '0;
        end else if (ctrl_cmd.load_status) begin
            m_status_reg       <= status_reg;
            m_comp_offset_reg  <= '0;
            m_comp_length_reg  <= '0;
            m_orig_offset_reg  <= '0;
            m_orig_length_reg  <= '0;
            m_inner_offset_reg <= '0;
            m_entry_hash_reg   <= '0;
        end
        if (ctrl_cmd.load_data || ctrl_cmd.load_status) begin
            m_entry_count_reg    <= count_reg;
            m_total_orig_len_reg <= total_orig_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_comp_offset    = m_comp_offset_reg;
    assign m_comp_length    = m_comp_length_reg;
    assign m_orig_offset    = m_orig_offset_reg;
    assign m_orig_length    = m_orig_length_reg;
    assign m_inner_offset   = m_inner_offset_reg;
    assign m_entry_hash     = m_entry_hash_reg;
    assign m_entry_count    = m_entry_count_reg;
    assign m_total_orig_len = m_total_orig_len_reg;

endmodule
